/* hw/rtl/pva_pkg.sv */
// Shared types and constants of the polyphonic voice allocator.
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int VOICE_W    = 3;
    localparam int VCNT_W     = 4;
    localparam int NUM_NOTES  = 128;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int ASG_W      = 5;
    localparam int VSTATE_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Operation codes
    localparam logic [2:0] OP_NOTE_ON = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_DEACT = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_FREE = 3'd1;
    localparam logic [2:0] ST_REL_VOICE = 3'd2;
    localparam logic [2:0] ST_STOLEN = 3'd3;
    localparam logic [2:0] ST_FREED = 3'd4;
    localparam logic [2:0] ST_RECOVERED = 3'd5;
    localparam logic [2:0] ST_MARKED = 3'd6;
    localparam logic [2:0] ST_READ = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOICES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 2'd2;

    typedef logic signed [VSTATE_W-1:0] vstate_t;
    typedef logic signed [ASG_W-1:0] asg_t;

    // Voice states
    localparam vstate_t VS_IDLE = -8'sd1;
    localparam vstate_t VS_RELEASING = -8'sd2;

    // Note assignment codes; non-negative values are voice indexes
    localparam asg_t NA_FREE = -5'sd1;
    localparam asg_t NA_RELEASING = -5'sd2;
    localparam asg_t NA_STOLEN = -5'sd3;

    typedef struct packed {
        logic              asg_we;
        logic              vel_we;
        logic [NOTE_W-1:0] waddr;
        asg_t              asg_wdata;
        logic [VEL_W-1:0]  vel_wdata;
        logic [NOTE_W-1:0] raddr;
    } ntab_req_t;

endpackage

`default_nettype wire

/* hw/rtl/poly_voice_allocator.sv */
// Top level of the polyphonic voice allocator with voice stealing.
//
// Usage: one item on the input channel (in_valid/in_ready) carries an
// operation (note on, note off, mark releasing, deactivate voice, read
// voice) with note, velocity and voice fields. Each item yields exactly one
// result on the output channel (out_valid/out_ready): status, voice index,
// that voice's state, velocity and pitch, and the active-voice count.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// voices-in-use count and the stealing and recovery enables; write it only
// while no item is in flight. cfg_ready is always high.
// Sequencing: a small sequencer walks the held-note stack memory, the note
// table and the voice table one step per cycle. Note off searches the stack
// and compacts it in one shared pass, then runs the recovery scan; note on
// searches the stack, scans the voices and may walk the stack to steal;
// read and unsupported operations go straight to the result. in_ready is
// high only while the sequencer is idle; the result sits in an output
// register, so the next item is taken while that result still waits for
// out_ready.
// Reset: all voices inactive, no note held, note table reads back as
// unassigned through valid bits, registers at 8 voices, stealing and
// recovery on. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module poly_voice_allocator
#(
    parameter int STACK_DEPTH = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input item channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  operation,
    input  wire logic [6:0]  note,
    input  wire logic [6:0]  velocity,
    input  wire logic [2:0]  voice,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [2:0]       voice_index,
    output logic signed [7:0] voice_state,
    output logic [6:0]       voice_velocity,
    output logic [6:0]       voice_pitch,
    output logic [3:0]       active_count,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int NV = pva_pkg::NUM_VOICES;

    // Sequencer states
    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_DISP       = 5'd1;
    localparam logic [4:0] S_FIND       = 5'd2;
    localparam logic [4:0] S_SHIFT      = 5'd3;
    localparam logic [4:0] S_CLR        = 5'd4;
    localparam logic [4:0] S_VHOLD      = 5'd5;
    localparam logic [4:0] S_VSCAN      = 5'd6;
    localparam logic [4:0] S_STEAL_RD   = 5'd7;
    localparam logic [4:0] S_STEAL_NT   = 5'd8;
    localparam logic [4:0] S_STEAL_CHK  = 5'd9;
    localparam logic [4:0] S_STEAL_MARK = 5'd10;
    localparam logic [4:0] S_ASSIGN     = 5'd11;
    localparam logic [4:0] S_REC_INIT   = 5'd12;
    localparam logic [4:0] S_REC_RD     = 5'd13;
    localparam logic [4:0] S_REC_NT     = 5'd14;
    localparam logic [4:0] S_REC_CHK    = 5'd15;
    localparam logic [4:0] S_FIN        = 5'd16;

    logic [4:0] state_reg, state_next;

    // latched item
    logic [2:0] op_reg;
    logic [6:0] note_reg;
    logic [6:0] vel_reg;
    logic [2:0] vsel_reg;

    // configuration
    logic [3:0] voices_reg;
    logic       steal_reg;
    logic       recover_reg;

    // working registers
    logic [2:0]    status_reg, status_next;
    logic [2:0]    vi_reg, vi_next;
    logic [CW-1:0] sidx_reg, sidx_next;
    logic          cmp_v_reg, cmp_v_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [pva_pkg::VCNT_W-1:0] vcnt_reg, vcnt_next;
    logic          rel_found_reg, rel_found_next;
    logic [2:0]    rel_idx_reg, rel_idx_next;
    logic [6:0]    cand_reg, cand_next;
    logic [CW-1:0] count_reg, count_next;

    // voice table
    pva_pkg::vstate_t vstate_reg [NV];
    pva_pkg::vstate_t vstate_next [NV];
    logic [6:0]       vvel_reg [NV];
    logic [6:0]       vvel_next [NV];
    logic [6:0]       vpitch_reg [NV];
    logic [6:0]       vpitch_next [NV];

    // held-note stack memory, newest entry at the highest index
    logic [6:0]    stk_mem [STACK_DEPTH];
    logic [6:0]    stk_rdata_reg;
    logic [AW-1:0] stk_raddr;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [6:0]    stk_wdata;

    pva_pkg::ntab_req_t ntab_req;
    pva_pkg::asg_t      ntab_asg;
    logic [6:0]         ntab_vel;

    logic          out_load;
    logic [3:0]    nv;
    logic [CW-1:0] sidx_m1;
    logic [CW-1:0] sidx_m2;
    pva_pkg::vstate_t note_state;
    logic [3:0]    act_cnt;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Clip the voices in use to the table size
    assign nv = (voices_reg > 4'(NV)) ? 4'(NV) : voices_reg;
    assign sidx_m1 = sidx_reg - CW'(1);
    assign sidx_m2 = sidx_reg - CW'(2);
    assign note_state = $signed({1'b0, note_reg});
    assign act_cnt = (count_reg < CW'(nv)) ? 4'(count_reg) : nv;

    pva_note_tab u_note_tab
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (ntab_req),
        .asg_rdata (ntab_asg),
        .vel_rdata (ntab_vel)
    );

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        vi_next        = vi_reg;
        sidx_next      = sidx_reg;
        cmp_v_next     = cmp_v_reg;
        wr_pend_next   = wr_pend_reg;
        vcnt_next      = vcnt_reg;
        rel_found_next = rel_found_reg;
        rel_idx_next   = rel_idx_reg;
        cand_next      = cand_reg;
        count_next     = count_reg;
        vstate_next    = vstate_reg;
        vvel_next      = vvel_reg;
        vpitch_next    = vpitch_reg;
        stk_raddr      = sidx_reg[AW-1:0];
        stk_we         = 1'b0;
        stk_waddr      = sidx_m2[AW-1:0];
        stk_wdata      = stk_rdata_reg;
        ntab_req           = '0;
        ntab_req.raddr     = stk_rdata_reg;
        ntab_req.waddr     = note_reg;
        ntab_req.asg_wdata = pva_pkg::NA_FREE;
        ntab_req.vel_wdata = vel_reg;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                status_next = pva_pkg::ST_NONE;
                vi_next     = '0;
                sidx_next   = '0;
                cmp_v_next  = 1'b0;
                case (op_reg)
                    pva_pkg::OP_NOTE_ON, pva_pkg::OP_NOTE_OFF, pva_pkg::OP_RELEASE:
                    begin
                        state_next = S_FIND;
                    end
                    pva_pkg::OP_DEACT:
                    begin
                        if (vstate_reg[vsel_reg] == pva_pkg::VS_RELEASING)
                        begin
                            vstate_next[vsel_reg] = pva_pkg::VS_IDLE;
                            vvel_next[vsel_reg]   = '0;
                            vi_next               = vsel_reg;
                            state_next            = S_REC_INIT;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    pva_pkg::OP_READ:
                    begin
                        status_next = pva_pkg::ST_READ;
                        vi_next     = vsel_reg;
                        state_next  = S_FIN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            // Search the stack, one entry per cycle; compare trails the read
            S_FIND:
            begin
                if (cmp_v_reg && (stk_rdata_reg == note_reg))
                begin
                    // sidx already points one past the match: compaction start
                    cmp_v_next   = 1'b0;
                    wr_pend_next = 1'b0;
                    state_next   = (op_reg == pva_pkg::OP_NOTE_ON) ? S_FIN : S_SHIFT;
                end
                else if (sidx_reg == count_reg)
                begin
                    cmp_v_next = 1'b0;
                    case (op_reg)
                        pva_pkg::OP_NOTE_ON:
                        begin
                            vcnt_next      = '0;
                            rel_found_next = 1'b0;
                            state_next     = (count_reg < CW'(STACK_DEPTH)) ? S_VSCAN : S_FIN;
                        end
                        pva_pkg::OP_NOTE_OFF:
                        begin
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
                else
                begin
                    stk_raddr  = sidx_reg[AW-1:0];
                    sidx_next  = sidx_reg + CW'(1);
                    cmp_v_next = 1'b1;
                end
            end

            // Close the gap: move each entry above the match down by one
            S_SHIFT:
            begin
                stk_we = wr_pend_reg;
                if (sidx_reg == count_reg)
                begin
                    wr_pend_next = 1'b0;
                    count_next   = count_reg - CW'(1);
                    state_next   = S_CLR;
                end
                else
                begin
                    stk_raddr    = sidx_reg[AW-1:0];
                    sidx_next    = sidx_reg + CW'(1);
                    wr_pend_next = 1'b1;
                end
            end

            S_CLR:
            begin
                ntab_req.asg_we    = 1'b1;
                ntab_req.asg_wdata = (op_reg == pva_pkg::OP_NOTE_OFF) ?
                                     pva_pkg::NA_FREE : pva_pkg::NA_RELEASING;
                vcnt_next          = '0;
                state_next         = S_VHOLD;
            end

            // Find the lowest voice sounding this note
            S_VHOLD:
            begin
                if (vcnt_reg == pva_pkg::VCNT_W'(NV))
                begin
                    state_next = S_FIN;
                end
                else if (vstate_reg[vcnt_reg[2:0]] == note_state)
                begin
                    vi_next                  = vcnt_reg[2:0];
                    vvel_next[vcnt_reg[2:0]] = '0;
                    if (op_reg == pva_pkg::OP_NOTE_OFF)
                    begin
                        vstate_next[vcnt_reg[2:0]] = pva_pkg::VS_IDLE;
                        state_next                 = S_REC_INIT;
                    end
                    else
                    begin
                        vstate_next[vcnt_reg[2:0]] = pva_pkg::VS_RELEASING;
                        status_next                = pva_pkg::ST_MARKED;
                        state_next                 = S_FIN;
                    end
                end
                else
                begin
                    vcnt_next = vcnt_reg + pva_pkg::VCNT_W'(1);
                end
            end

            // Lowest free voice wins; remember the lowest releasing one
            S_VSCAN:
            begin
                if (vcnt_reg == nv)
                begin
                    if (rel_found_reg)
                    begin
                        vi_next     = rel_idx_reg;
                        status_next = pva_pkg::ST_REL_VOICE;
                        state_next  = S_ASSIGN;
                    end
                    else if (steal_reg)
                    begin
                        sidx_next  = '0;
                        state_next = S_STEAL_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (vstate_reg[vcnt_reg[2:0]] == pva_pkg::VS_IDLE)
                begin
                    vi_next     = vcnt_reg[2:0];
                    status_next = pva_pkg::ST_FREE;
                    state_next  = S_ASSIGN;
                end
                else
                begin
                    if ((vstate_reg[vcnt_reg[2:0]] == pva_pkg::VS_RELEASING) && !rel_found_reg)
                    begin
                        rel_found_next = 1'b1;
                        rel_idx_next   = vcnt_reg[2:0];
                    end
                    vcnt_next = vcnt_reg + pva_pkg::VCNT_W'(1);
                end
            end

            // Walk from the oldest held note for one that owns a voice
            S_STEAL_RD:
            begin
                if (sidx_reg == count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    stk_raddr  = sidx_reg[AW-1:0];
                    state_next = S_STEAL_NT;
                end
            end

            S_STEAL_NT:
            begin
                state_next = S_STEAL_CHK;
            end

            S_STEAL_CHK:
            begin
                if (ntab_asg[pva_pkg::ASG_W-1:pva_pkg::VOICE_W] == '0)
                begin
                    vi_next     = ntab_asg[pva_pkg::VOICE_W-1:0];
                    status_next = pva_pkg::ST_STOLEN;
                    state_next  = S_STEAL_MARK;
                end
                else
                begin
                    sidx_next  = sidx_reg + CW'(1);
                    state_next = S_STEAL_RD;
                end
            end

            S_STEAL_MARK:
            begin
                if (!vstate_reg[vi_reg][7])
                begin
                    ntab_req.asg_we    = 1'b1;
                    ntab_req.waddr     = vstate_reg[vi_reg][6:0];
                    ntab_req.asg_wdata = pva_pkg::NA_STOLEN;
                end
                state_next = S_ASSIGN;
            end

            // Give the voice to the new note and push the note
            S_ASSIGN:
            begin
                vstate_next[vi_reg] = note_state;
                vvel_next[vi_reg]   = vel_reg;
                vpitch_next[vi_reg] = note_reg;
                ntab_req.asg_we     = 1'b1;
                ntab_req.vel_we     = 1'b1;
                ntab_req.asg_wdata  = $signed({2'b00, vi_reg});
                stk_we              = 1'b1;
                stk_waddr           = count_reg[AW-1:0];
                stk_wdata           = note_reg;
                count_next          = count_reg + CW'(1);
                state_next          = S_FIN;
            end

            S_REC_INIT:
            begin
                if (!recover_reg)
                begin
                    status_next = pva_pkg::ST_FREED;
                    state_next  = S_FIN;
                end
                else
                begin
                    sidx_next  = count_reg;
                    state_next = S_REC_RD;
                end
            end

            // Walk from the newest held note for a stolen one
            S_REC_RD:
            begin
                if (sidx_reg == '0)
                begin
                    status_next = pva_pkg::ST_FREED;
                    state_next  = S_FIN;
                end
                else
                begin
                    stk_raddr  = sidx_m1[AW-1:0];
                    sidx_next  = sidx_m1;
                    state_next = S_REC_NT;
                end
            end

            S_REC_NT:
            begin
                cand_next  = stk_rdata_reg;
                state_next = S_REC_CHK;
            end

            S_REC_CHK:
            begin
                if (ntab_asg == pva_pkg::NA_STOLEN)
                begin
                    vstate_next[vi_reg] = $signed({1'b0, cand_reg});
                    vvel_next[vi_reg]   = ntab_vel;
                    vpitch_next[vi_reg] = cand_reg;
                    ntab_req.asg_we     = 1'b1;
                    ntab_req.waddr      = cand_reg;
                    ntab_req.asg_wdata  = $signed({2'b00, vi_reg});
                    status_next         = pva_pkg::ST_RECOVERED;
                    state_next          = S_FIN;
                end
                else
                begin
                    state_next = S_REC_RD;
                end
            end

            // Hold the result until the output register is free
            S_FIN:
            begin
                if (!out_valid || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= pva_pkg::ST_NONE;
            vi_reg        <= '0;
            sidx_reg      <= '0;
            cmp_v_reg     <= 1'b0;
            wr_pend_reg   <= 1'b0;
            vcnt_reg      <= '0;
            rel_found_reg <= 1'b0;
            rel_idx_reg   <= '0;
            count_reg     <= '0;
            voices_reg    <= 4'(NV);
            steal_reg     <= 1'b1;
            recover_reg   <= 1'b1;
            out_valid     <= 1'b0;
            for (int i = 0; i < NV; i++)
            begin
                vstate_reg[i] <= pva_pkg::VS_IDLE;
                vvel_reg[i]   <= '0;
                vpitch_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            vi_reg        <= vi_next;
            sidx_reg      <= sidx_next;
            cmp_v_reg     <= cmp_v_next;
            wr_pend_reg   <= wr_pend_next;
            vcnt_reg      <= vcnt_next;
            rel_found_reg <= rel_found_next;
            rel_idx_reg   <= rel_idx_next;
            count_reg     <= count_next;
            vstate_reg    <= vstate_next;
            vvel_reg      <= vvel_next;
            vpitch_reg    <= vpitch_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pva_pkg::CFG_VOICES:  voices_reg  <= cfg_data;
                    pva_pkg::CFG_STEAL:   steal_reg   <= cfg_data[0];
                    pva_pkg::CFG_RECOVER: recover_reg <= cfg_data[0];
                    default:              ;
                endcase
            end
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: item latch, candidate note, result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= operation;
            note_reg <= note;
            vel_reg  <= velocity;
            vsel_reg <= voice;
        end
        cand_reg <= cand_next;
        if (out_load)
        begin
            status       <= status_reg;
            active_count <= act_cnt;
            if (status_reg != pva_pkg::ST_NONE)
            begin
                voice_index    <= vi_reg;
                voice_state    <= vstate_reg[vi_reg];
                voice_velocity <= vvel_reg[vi_reg];
                voice_pitch    <= vpitch_reg[vi_reg];
            end
            else
            begin
                voice_index    <= '0;
                voice_state    <= '0;
                voice_velocity <= '0;
                voice_pitch    <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("held note count beyond stack depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after an accepted item");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active_count <= nv))
        else $error("active count above voices in use");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == pva_pkg::ST_NONE)) |->
        ((voice_index == '0) && (voice_state == '0) && (voice_pitch == '0)))
        else $error("empty result carries voice data");

endmodule

`default_nettype wire

/* hw/rtl/pva_note_tab.sv */
// Note table: per-note voice assignment and velocity with reset-valid bits.
`timescale 1ns / 1ps
`default_nettype none

module pva_note_tab
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pva_pkg::ntab_req_t req,
    output pva_pkg::asg_t          asg_rdata,
    output logic [pva_pkg::VEL_W-1:0] vel_rdata
);

    pva_pkg::asg_t                asg_mem [pva_pkg::NUM_NOTES];
    logic [pva_pkg::VEL_W-1:0]    vel_mem [pva_pkg::NUM_NOTES];
    logic [pva_pkg::NUM_NOTES-1:0] asg_vld_reg;
    logic [pva_pkg::NUM_NOTES-1:0] vel_vld_reg;
    pva_pkg::asg_t                asg_q_reg;
    logic [pva_pkg::VEL_W-1:0]    vel_q_reg;
    logic                         asg_vq_reg;
    logic                         vel_vq_reg;

    // Entries never written read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asg_vld_reg <= '0;
            vel_vld_reg <= '0;
            asg_vq_reg  <= 1'b0;
            vel_vq_reg  <= 1'b0;
        end
        else
        begin
            if (req.asg_we)
            begin
                asg_vld_reg[req.waddr] <= 1'b1;
            end
            if (req.vel_we)
            begin
                vel_vld_reg[req.waddr] <= 1'b1;
            end
            asg_vq_reg <= asg_vld_reg[req.raddr];
            vel_vq_reg <= vel_vld_reg[req.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.asg_we)
        begin
            asg_mem[req.waddr] <= req.asg_wdata;
        end
        if (req.vel_we)
        begin
            vel_mem[req.waddr] <= req.vel_wdata;
        end
        asg_q_reg <= asg_mem[req.raddr];
        vel_q_reg <= vel_mem[req.raddr];
    end

    assign asg_rdata = asg_vq_reg ? asg_q_reg : pva_pkg::NA_FREE;
    assign vel_rdata = vel_vq_reg ? vel_q_reg : '0;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the polyphonic voice allocator.
`timescale 1ns / 1ps

typedef struct {
    logic [2:0]        st;
    logic [2:0]        vi;
    logic signed [7:0] vs;
    logic [6:0]        vv;
    logic [6:0]        vp;
    logic [3:0]        ac;
} voice_report_t;

class voice_scoreboard;
    int                voice_note[pva_pkg::NUM_VOICES];
    logic [6:0]        voice_vel[pva_pkg::NUM_VOICES];
    logic [6:0]        voice_pitch[pva_pkg::NUM_VOICES];
    int                note_owner[pva_pkg::NUM_NOTES];
    logic [6:0]        note_vel[pva_pkg::NUM_NOTES];
    logic [6:0]        held[pva_pkg::NUM_NOTES];
    int                held_cnt;
    int                voices_cfg;
    bit                steal_on;
    bit                recover_on;
    voice_report_t     pending[$];
    int                mismatches;
    int                checked;

    function new();
        for (int i = 0; i < pva_pkg::NUM_VOICES; i++)
        begin
            voice_note[i] = -1;
            voice_vel[i] = 0;
            voice_pitch[i] = 0;
        end
        for (int i = 0; i < pva_pkg::NUM_NOTES; i++)
        begin
            note_owner[i] = -1;
            note_vel[i] = 0;
            held[i] = 0;
        end
        held_cnt = 0;
        voices_cfg = 8;
        steal_on = 1;
        recover_on = 1;
        mismatches = 0;
        checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] data);
        if (idx == pva_pkg::CFG_VOICES) voices_cfg = int'(data);
        else if (idx == pva_pkg::CFG_STEAL) steal_on = data[0];
        else if (idx == pva_pkg::CFG_RECOVER) recover_on = data[0];
    endfunction

    function int held_pos(int n);
        for (int i = 0; i < held_cnt; i++)
            if (int'(held[i]) == n) return i;
        return -1;
    endfunction

    function bit drop_held(int n);
        int pos;
        pos = held_pos(n);
        if (pos < 0) return 0;
        for (int i = pos; i + 1 < held_cnt; i++) held[i] = held[i + 1];
        held_cnt--;
        return 1;
    endfunction

    function void give_voice(int v, int n, logic [6:0] vel);
        voice_note[v] = n;
        voice_vel[v] = vel;
        voice_pitch[v] = 7'(n);
        note_owner[n] = v;
        note_vel[n] = vel;
        for (int i = held_cnt; i > 0; i--) held[i] = held[i - 1];
        held[0] = 7'(n);
        held_cnt++;
    endfunction

    // Hand a freed voice to the newest stolen note still held.
    function bit hand_back(int v);
        int n;
        if (!recover_on) return 0;
        for (int j = 0; j < held_cnt; j++)
        begin
            n = int'(held[j]);
            if (note_owner[n] == int'(pva_pkg::NA_STOLEN))
            begin
                voice_note[v] = n;
                voice_vel[v] = note_vel[n];
                voice_pitch[v] = 7'(n);
                note_owner[n] = v;
                return 1;
            end
        end
        return 0;
    endfunction

    function int voice_of(int n);
        for (int i = 0; i < pva_pkg::NUM_VOICES; i++)
            if (voice_note[i] == n) return i;
        return -1;
    endfunction

    function int releasing_voice();
        for (int i = 0; i < pva_pkg::NUM_VOICES; i++)
            if (voice_note[i] == int'(pva_pkg::VS_RELEASING)) return i;
        return int'($urandom_range(0, 7));
    endfunction

    function int held_note();
        if (held_cnt == 0) return int'($urandom_range(0, 15));
        return int'(held[$urandom_range(0, held_cnt - 1)]);
    endfunction

    // Note an accepted item: advance the allocation state, queue its report.
    function void note_item(logic [2:0] op, logic [6:0] n, logic [6:0] vel,
                            logic [2:0] vsel);
        int nv;
        int w;
        int prev;
        voice_report_t r;
        nv = (voices_cfg > pva_pkg::NUM_VOICES) ? pva_pkg::NUM_VOICES : voices_cfg;
        r.st = pva_pkg::ST_NONE;
        r.vi = 0;
        case (op)
            pva_pkg::OP_NOTE_ON:
            begin
                if (held_pos(int'(n)) < 0 && held_cnt < pva_pkg::NUM_NOTES)
                begin
                    for (int i = 0; i < nv && r.st == pva_pkg::ST_NONE; i++)
                        if (voice_note[i] == int'(pva_pkg::VS_IDLE))
                        begin
                            give_voice(i, int'(n), vel);
                            r.st = pva_pkg::ST_FREE;
                            r.vi = 3'(i);
                        end
                    for (int i = 0; i < nv && r.st == pva_pkg::ST_NONE; i++)
                        if (voice_note[i] == int'(pva_pkg::VS_RELEASING))
                        begin
                            give_voice(i, int'(n), vel);
                            r.st = pva_pkg::ST_REL_VOICE;
                            r.vi = 3'(i);
                        end
                    if (r.st == pva_pkg::ST_NONE && steal_on)
                    begin
                        for (int i = held_cnt; i > 0; i--)
                        begin
                            w = note_owner[held[i - 1]];
                            if (w >= 0 && w < pva_pkg::NUM_VOICES)
                            begin
                                prev = voice_note[w];
                                if (prev >= 0) note_owner[prev] = int'(pva_pkg::NA_STOLEN);
                                give_voice(w, int'(n), vel);
                                r.st = pva_pkg::ST_STOLEN;
                                r.vi = 3'(w);
                                break;
                            end
                        end
                    end
                end
            end
            pva_pkg::OP_NOTE_OFF:
            begin
                void'(drop_held(int'(n)));
                note_owner[n] = int'(pva_pkg::NA_FREE);
                w = voice_of(int'(n));
                if (w >= 0)
                begin
                    voice_note[w] = int'(pva_pkg::VS_IDLE);
                    voice_vel[w] = 0;
                    r.vi = 3'(w);
                    r.st = hand_back(w) ? pva_pkg::ST_RECOVERED : pva_pkg::ST_FREED;
                end
            end
            pva_pkg::OP_RELEASE:
            begin
                if (drop_held(int'(n)))
                begin
                    note_owner[n] = int'(pva_pkg::NA_RELEASING);
                    w = voice_of(int'(n));
                    if (w >= 0)
                    begin
                        voice_note[w] = int'(pva_pkg::VS_RELEASING);
                        voice_vel[w] = 0;
                        r.vi = 3'(w);
                        r.st = pva_pkg::ST_MARKED;
                    end
                end
            end
            pva_pkg::OP_DEACT:
            begin
                if (voice_note[vsel] == int'(pva_pkg::VS_RELEASING))
                begin
                    voice_note[vsel] = int'(pva_pkg::VS_IDLE);
                    voice_vel[vsel] = 0;
                    r.vi = vsel;
                    r.st = hand_back(int'(vsel)) ? pva_pkg::ST_RECOVERED
                                                 : pva_pkg::ST_FREED;
                end
            end
            pva_pkg::OP_READ:
            begin
                r.st = pva_pkg::ST_READ;
                r.vi = vsel;
            end
            default: ;
        endcase
        if (r.st != pva_pkg::ST_NONE)
        begin
            r.vs = 8'(voice_note[r.vi]);
            r.vv = voice_vel[r.vi];
            r.vp = voice_pitch[r.vi];
        end
        else
        begin
            r.vs = 0;
            r.vv = 0;
            r.vp = 0;
        end
        r.ac = 4'((held_cnt < nv) ? held_cnt : nv);
        pending.push_back(r);
    endfunction

    function void check_result(voice_report_t got);
        voice_report_t exp_r;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with nothing pending, status %0d", got.st);
            return;
        end
        exp_r = pending.pop_front();
        if (got.st !== exp_r.st || got.vi !== exp_r.vi || got.vs !== exp_r.vs ||
            got.vv !== exp_r.vv || got.vp !== exp_r.vp || got.ac !== exp_r.ac)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: result %0d exp st=%0d vi=%0d vs=%0d vv=%0d vp=%0d ",
                          "ac=%0d, got st=%0d vi=%0d vs=%0d vv=%0d vp=%0d ac=%0d"},
                         checked, exp_r.st, exp_r.vi, exp_r.vs, exp_r.vv, exp_r.vp,
                         exp_r.ac, got.st, got.vi, got.vs, got.vv, got.vp, got.ac);
        end
    endfunction
endclass

module tb_top;
    localparam int STALL_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        operation;
    logic [6:0]        note;
    logic [6:0]        velocity;
    logic [2:0]        voice;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        status;
    logic [2:0]        voice_index;
    logic signed [7:0] voice_state;
    logic [6:0]        voice_velocity;
    logic [6:0]        voice_pitch;
    logic [3:0]        active_count;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [3:0]        cfg_data;

    voice_scoreboard   sb;
    int                idle_cycles = 0;
    int                items_sent;
    int                cfg_writes;
    int                calm_in;
    int                calm_out = 0;
    int                out_hold = 0;

    poly_voice_allocator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .note           (note),
        .velocity       (velocity),
        .voice          (voice),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .voice_index    (voice_index),
        .voice_state    (voice_state),
        .voice_velocity (voice_velocity),
        .voice_pitch    (voice_pitch),
        .active_count   (active_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Gap length: mostly none or short, now and then long; a calm stretch
    // forces back-to-back traffic for a while.
    function automatic int pick_gap(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 3) calm = int'($urandom_range(10, 40));
        if (r < 50) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // Drive one item; keep valid high across back-to-back items.
    task automatic send(logic [2:0] op, logic [6:0] n, logic [6:0] vel, logic [2:0] vsel);
        int gap;
        gap = pick_gap(calm_in);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        note      <= n;
        velocity  <= vel;
        voice     <= vsel;
        do @(posedge clk); while (!in_ready);
        sb.note_item(op, n, vel, vsel);
        items_sent++;
    endtask

    // Drain all pending results, let the sequencer settle, then write.
    task automatic write_reg(logic [1:0] idx, logic [3:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(int nv, bit steal, bit recov);
        write_reg(pva_pkg::CFG_VOICES, 4'(nv));
        write_reg(pva_pkg::CFG_STEAL, {3'b000, steal});
        write_reg(pva_pkg::CFG_RECOVER, {3'b000, recov});
    endtask

    // Random item: mostly held notes so sequences go deep, some noise.
    task automatic random_item();
        int r;
        logic [6:0] n;
        r = int'($urandom_range(0, 99));
        n = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 15));
        if (r < 38)
            send(pva_pkg::OP_NOTE_ON, n, 7'($urandom_range(0, 127)),
                 3'($urandom_range(0, 7)));
        else if (r < 58)
            send(pva_pkg::OP_NOTE_OFF, ($urandom_range(0, 3) != 0) ? 7'(sb.held_note()) : n,
                 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
        else if (r < 73)
            send(pva_pkg::OP_RELEASE, ($urandom_range(0, 3) != 0) ? 7'(sb.held_note()) : n,
                 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
        else if (r < 86)
            send(pva_pkg::OP_DEACT, n, 7'($urandom_range(0, 127)),
                 ($urandom_range(0, 3) != 0) ? 3'(sb.releasing_voice())
                                             : 3'($urandom_range(0, 7)));
        else if (r < 96)
            send(pva_pkg::OP_READ, n, 7'($urandom_range(0, 127)),
                 3'($urandom_range(0, 7)));
        else
            send(3'($urandom_range(5, 7)), n, 7'($urandom_range(0, 127)),
                 3'($urandom_range(0, 7)));
    endtask

    // Result side: stall at random, sample at the rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_hold > 0)
            begin
                out_hold <= out_hold - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_hold <= pick_gap(calm_out);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(voice_report_t'{status, voice_index, voice_state,
                                            voice_velocity, voice_pitch, active_count});
    end

    // Watchdog: count cycles in which no handshake completes.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int v;
        sb = new();
        items_sent = 0;
        cfg_writes = 0;
        calm_in = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = pva_pkg::OP_READ;
        note = 0;
        velocity = 0;
        voice = 0;
        cfg_valid = 1'b0;
        cfg_index = pva_pkg::CFG_VOICES;
        cfg_data = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every operation, the corner cases.
        send(pva_pkg::OP_READ, 0, 0, 0);
        send(pva_pkg::OP_NOTE_ON, 0, 127, 0);
        send(pva_pkg::OP_NOTE_ON, 127, 0, 7);
        send(pva_pkg::OP_NOTE_ON, 127, 55, 0);    // already held
        send(pva_pkg::OP_READ, 0, 0, 7);
        send(pva_pkg::OP_RELEASE, 127, 0, 0);
        send(pva_pkg::OP_RELEASE, 127, 0, 0);     // no longer held
        send(pva_pkg::OP_DEACT, 0, 0, 1);         // voice 1 is releasing
        send(pva_pkg::OP_DEACT, 0, 0, 0);         // voice 0 not releasing
        send(pva_pkg::OP_NOTE_OFF, 99, 0, 0);     // never held
        send(3'd5, 127, 127, 7);
        send(3'd6, 0, 0, 0);
        send(3'd7, 85, 42, 5);
        send(pva_pkg::OP_NOTE_OFF, 0, 0, 0);
        set_mode(1, 1, 1);
        send(pva_pkg::OP_NOTE_ON, 10, 100, 0);
        send(pva_pkg::OP_NOTE_ON, 11, 90, 0);     // steals from note 10
        send(pva_pkg::OP_RELEASE, 10, 0, 0);      // held, no voice
        send(pva_pkg::OP_NOTE_ON, 12, 80, 0);     // steals again
        send(pva_pkg::OP_NOTE_OFF, 12, 0, 0);     // recovers for note 11
        send(pva_pkg::OP_NOTE_OFF, 11, 0, 0);
        set_mode(0, 1, 1);
        send(pva_pkg::OP_NOTE_ON, 20, 1, 0);      // nothing searched
        send(pva_pkg::OP_READ, 20, 0, 3);

        // Fill the held stack with every note, then empty it again.
        set_mode(15, 1, 1);
        for (int i = 0; i < pva_pkg::NUM_NOTES + 2; i++)
            send(pva_pkg::OP_NOTE_ON, 7'((i * 37) % pva_pkg::NUM_NOTES),
                 7'($urandom_range(0, 127)), 0);
        for (int i = 0; i < pva_pkg::NUM_NOTES; i++)
            send(pva_pkg::OP_NOTE_OFF, 7'(i), 0, 0);

        // Random phases across register settings.
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_mode(8, 1, 1);
                1: set_mode(1, 1, 0);
                2: set_mode(0, 1, 1);
                3: set_mode(15, 0, 1);
                4: set_mode(3, 1, 1);
                5: set_mode(8, 0, 0);
                default:
                begin
                    v = int'($urandom_range(0, 15));
                    set_mode(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            endcase
            for (int k = 0; k < 60; k++) random_item();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Run covered %0d items and %0d register writes; %0d results checked.",
                 items_sent, cfg_writes, sb.checked);
        $display("Settings spanned 0 to 15 voices, stealing and recovery on and off.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/pva_pkg.sv
hw/rtl/pva_note_tab.sv
hw/rtl/poly_voice_allocator.sv
test/tb_top.sv
